// ===== rtl/sdr_pkg.sv =====
`default_nettype none

package sdr_pkg;

    // default operand width
    localparam int DATA_WIDTH_DEF = 32;

    // result status codes
    localparam int STATUS_W = 2;
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_DIV_ZERO = 2'd1;
    localparam status_t ST_OVERFLOW = 2'd2;

    // cycle cost estimate: setup + per-loop * loops + tail, wrapped to COST_W bits
    localparam int COST_W = 9;
    localparam logic [COST_W-1:0] COST_SETUP    = 9'd40;
    localparam logic [COST_W-1:0] COST_PER_LOOP = 9'd13;
    localparam logic [COST_W-1:0] COST_TAIL     = 9'd8;

    // control bits that travel with each item down the cell chain
    typedef struct packed {
        logic    neg_q;    // quotient gets negated at the end
        logic    neg_r;    // remainder gets negated at the end
        status_t status;
        logic    found_n;  // a one bit of the raw dividend has been seen
        logic    found_d;  // a one bit of the raw divisor has been seen
    } sdr_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sdr_prep.sv =====
`default_nettype none

module sdr_prep
    import sdr_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // operand side
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [DATA_WIDTH-1:0]  in_dividend,
    input  wire logic [DATA_WIDTH-1:0]  in_divisor,
    // first cell side
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output sdr_ctrl_t                   out_ctrl,
    output logic [DATA_WIDTH-1:0]       out_num,
    output logic [DATA_WIDTH-1:0]       out_dmag,
    output logic [DATA_WIDTH-1:0]       out_rawn,
    output logic [DATA_WIDTH-1:0]       out_rawd
);

    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                  valid_reg;
    logic                  load;
    sdr_ctrl_t             ctrl_reg, ctrl_next;
    logic [DATA_WIDTH-1:0] num_reg, num_next;
    logic [DATA_WIDTH-1:0] dmag_reg, dmag_next;
    logic [DATA_WIDTH-1:0] rawn_reg;
    logic [DATA_WIDTH-1:0] rawd_reg;

    // stage takes a new item when empty or when it hands its item on
    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // magnitudes, signs and error status
    always_comb begin
        num_next  = in_dividend[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - in_dividend) : in_dividend;
        dmag_next = in_divisor[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - in_divisor) : in_divisor;
        ctrl_next.neg_q   = in_dividend[DATA_WIDTH-1] ^ in_divisor[DATA_WIDTH-1];
        ctrl_next.neg_r   = in_dividend[DATA_WIDTH-1];
        ctrl_next.found_n = 1'b0;
        ctrl_next.found_d = 1'b0;
        if (in_divisor == '0) begin
            ctrl_next.status = ST_DIV_ZERO;
        end else if (in_dividend == MIN_VAL && (&in_divisor)) begin
            ctrl_next.status = ST_OVERFLOW;
        end else begin
            ctrl_next.status = ST_OK;
        end
    end

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            ctrl_reg <= ctrl_next;
            num_reg  <= num_next;
            dmag_reg <= dmag_next;
            rawn_reg <= in_dividend;
            rawd_reg <= in_divisor;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_num   = num_reg;
    assign out_dmag  = dmag_reg;
    assign out_rawn  = rawn_reg;
    assign out_rawd  = rawd_reg;

endmodule

`default_nettype wire

// ===== rtl/sdr_cell.sv =====
`default_nettype none

module sdr_cell
    import sdr_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DATA_WIDTH + 1)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // from previous cell
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire sdr_ctrl_t              in_ctrl,
    input  wire logic [DATA_WIDTH-1:0]  in_rem,
    input  wire logic [DATA_WIDTH-1:0]  in_num,
    input  wire logic [DATA_WIDTH-1:0]  in_dmag,
    input  wire logic [DATA_WIDTH-1:0]  in_rawn,
    input  wire logic [DATA_WIDTH-1:0]  in_rawd,
    input  wire logic [CNT_W-1:0]       in_lzn,
    input  wire logic [CNT_W-1:0]       in_lzd,
    // to next cell
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output sdr_ctrl_t                   out_ctrl,
    output logic [DATA_WIDTH-1:0]       out_rem,
    output logic [DATA_WIDTH-1:0]       out_num,
    output logic [DATA_WIDTH-1:0]       out_dmag,
    output logic [DATA_WIDTH-1:0]       out_rawn,
    output logic [DATA_WIDTH-1:0]       out_rawd,
    output logic [CNT_W-1:0]            out_lzn,
    output logic [CNT_W-1:0]            out_lzd
);

    logic                  valid_reg;
    logic                  load;
    logic [DATA_WIDTH:0]   rem_shift;
    logic [DATA_WIDTH:0]   diff;
    logic                  qbit;
    logic                  bit_n, bit_d;
    sdr_ctrl_t             ctrl_reg, ctrl_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] num_reg, num_next;
    logic [DATA_WIDTH-1:0] dmag_reg;
    logic [DATA_WIDTH-1:0] rawn_reg, rawd_reg;
    logic [CNT_W-1:0]      lzn_reg, lzn_next;
    logic [CNT_W-1:0]      lzd_reg, lzd_next;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // one restoring step: shift in the next dividend bit, try to subtract
    always_comb begin
        rem_shift = {in_rem, in_num[DATA_WIDTH-1]};
        diff      = rem_shift - {1'b0, in_dmag};
        qbit      = !diff[DATA_WIDTH];
        rem_next  = qbit ? diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
        num_next  = {in_num[DATA_WIDTH-2:0], qbit};
    end

    // one bit of the leading-zero counts of the raw operands
    always_comb begin
        bit_n     = in_rawn[DATA_WIDTH-1];
        bit_d     = in_rawd[DATA_WIDTH-1];
        ctrl_next = in_ctrl;
        ctrl_next.found_n = in_ctrl.found_n | bit_n;
        ctrl_next.found_d = in_ctrl.found_d | bit_d;
        lzn_next  = (in_ctrl.found_n || bit_n) ? in_lzn : (in_lzn + 1'b1);
        lzd_next  = (in_ctrl.found_d || bit_d) ? in_lzd : (in_lzd + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            ctrl_reg <= ctrl_next;
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            dmag_reg <= in_dmag;
            rawn_reg <= {in_rawn[DATA_WIDTH-2:0], 1'b0};
            rawd_reg <= {in_rawd[DATA_WIDTH-2:0], 1'b0};
            lzn_reg  <= lzn_next;
            lzd_reg  <= lzd_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_dmag  = dmag_reg;
    assign out_rawn  = rawn_reg;
    assign out_rawd  = rawd_reg;
    assign out_lzn   = lzn_reg;
    assign out_lzd   = lzd_reg;

endmodule

`default_nettype wire

// ===== rtl/sdr_post.sv =====
`default_nettype none

module sdr_post
    import sdr_pkg::*;
#(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int CNT_W       = $clog2(DATA_WIDTH + 1),
    parameter int OUT_TDATA_W = ((3 * DATA_WIDTH + COST_W + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // from last cell
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire sdr_ctrl_t              in_ctrl,
    input  wire logic [DATA_WIDTH-1:0]  in_rem,
    input  wire logic [DATA_WIDTH-1:0]  in_num,
    input  wire logic [CNT_W-1:0]       in_lzn,
    input  wire logic [CNT_W-1:0]       in_lzd,
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic [STATUS_W-1:0]         m_tuser
);

    logic                   valid_reg;
    logic                   load;
    logic [DATA_WIDTH-1:0]  quot, rem, qmag;
    logic [CNT_W-1:0]       loops;
    logic [COST_W-1:0]      cost;
    logic [OUT_TDATA_W-1:0] tdata_reg, tdata_next;
    status_t                tuser_reg;

    assign load     = !valid_reg || m_tready;
    assign in_ready = load;

    // sign fix, loop count and cost, zero fields on error
    always_comb begin
        loops = (in_lzd > in_lzn) ? (in_lzd - in_lzn) : CNT_W'(1);
        cost  = COST_SETUP + COST_PER_LOOP * COST_W'(loops) + COST_TAIL;
        qmag  = in_num;
        quot  = in_ctrl.neg_q ? (DATA_WIDTH'(0) - in_num) : in_num;
        rem   = in_ctrl.neg_r ? (DATA_WIDTH'(0) - in_rem) : in_rem;
        if (in_ctrl.status == ST_OK) begin
            tdata_next = OUT_TDATA_W'({cost, qmag, rem, quot});
        end else begin
            tdata_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            tdata_reg <= tdata_next;
            tuser_reg <= in_ctrl.status;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

`default_nettype wire

// ===== rtl/signed_divide_remainder.sv =====
// signed divider with remainder, quotient magnitude, status and cycle-cost estimate
//
// input stream s_*: one transfer carries a dividend and a divisor, both two's
// complement. result stream m_*: one transfer per input transfer, in order,
// with quotient (truncated toward zero), remainder (sign of the dividend),
// quotient magnitude and cost in tdata, and the status code in tuser
// (0 ok, 1 divide by zero, 2 signed overflow; value fields are zero on error).
//
// an item passes DATA_WIDTH + 2 register stages: one operand stage, one
// restoring cell per quotient bit, one output register. while m_tready is
// high, throughput is one item per cycle, set by the cell chain in which
// every cell retires one quotient bit per item.
//
// reset clears every stage valid bit; the chain is empty afterwards.
// when m_tready is low the output register holds its result and each stage
// keeps filling while a bubble lies ahead of it; s_tready falls only once
// all DATA_WIDTH + 2 stages hold items.
`default_nettype none

module signed_divide_remainder
    import sdr_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // dividend [DATA_WIDTH-1:0], divisor [2*DATA_WIDTH-1:DATA_WIDTH], zero pad
    input  wire logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // quotient, remainder, quotient_magnitude, cycle_cost (9 bits), zero pad
    output logic [((3 * DATA_WIDTH + COST_W + 7) / 8) * 8 - 1:0] m_tdata,
    // status (2 bits)
    output logic [STATUS_W-1:0]         m_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready
);

    localparam int CNT_W       = $clog2(DATA_WIDTH + 1);
    localparam int OUT_TDATA_W = ((3 * DATA_WIDTH + COST_W + 7) / 8) * 8;

    // links between stages; index 0 is the operand stage output
    logic                  valid_w [0:DATA_WIDTH];
    logic                  ready_w [0:DATA_WIDTH];
    sdr_ctrl_t             ctrl_w  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_w   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] num_w   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] dmag_w  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rawn_w  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rawd_w  [0:DATA_WIDTH];
    logic [CNT_W-1:0]      lzn_w   [0:DATA_WIDTH];
    logic [CNT_W-1:0]      lzd_w   [0:DATA_WIDTH];

    // operand stage
    sdr_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_dividend (s_tdata[DATA_WIDTH-1:0]),
        .in_divisor  (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .out_valid   (valid_w[0]),
        .out_ready   (ready_w[0]),
        .out_ctrl    (ctrl_w[0]),
        .out_num     (num_w[0]),
        .out_dmag    (dmag_w[0]),
        .out_rawn    (rawn_w[0]),
        .out_rawd    (rawd_w[0])
    );

    // partial remainder and leading-zero counts start at zero
    assign rem_w[0] = '0;
    assign lzn_w[0] = '0;
    assign lzd_w[0] = '0;

    // one cell per quotient bit
    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
        sdr_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_w[i]),
            .in_ready  (ready_w[i]),
            .in_ctrl   (ctrl_w[i]),
            .in_rem    (rem_w[i]),
            .in_num    (num_w[i]),
            .in_dmag   (dmag_w[i]),
            .in_rawn   (rawn_w[i]),
            .in_rawd   (rawd_w[i]),
            .in_lzn    (lzn_w[i]),
            .in_lzd    (lzd_w[i]),
            .out_valid (valid_w[i+1]),
            .out_ready (ready_w[i+1]),
            .out_ctrl  (ctrl_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_num   (num_w[i+1]),
            .out_dmag  (dmag_w[i+1]),
            .out_rawn  (rawn_w[i+1]),
            .out_rawd  (rawd_w[i+1]),
            .out_lzn   (lzn_w[i+1]),
            .out_lzd   (lzd_w[i+1])
        );
    end

    // sign fix and output register
    sdr_post #(
        .DATA_WIDTH  (DATA_WIDTH),
        .CNT_W       (CNT_W),
        .OUT_TDATA_W (OUT_TDATA_W)
    ) u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (valid_w[DATA_WIDTH]),
        .in_ready (ready_w[DATA_WIDTH]),
        .in_ctrl  (ctrl_w[DATA_WIDTH]),
        .in_rem   (rem_w[DATA_WIDTH]),
        .in_num   (num_w[DATA_WIDTH]),
        .in_lzn   (lzn_w[DATA_WIDTH]),
        .in_lzd   (lzd_w[DATA_WIDTH]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
